### rtl/isg_pkg.sv
// ----------------------------------------------------------------------------
// isg_pkg
// Types and constants shared by the inertial scroll gesture block.
// ----------------------------------------------------------------------------
package isg_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_ACCEPT_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_BOUND_LOW        = 2'd1;
	localparam logic [1:0] REG_BOUND_HIGH       = 2'd2;

	localparam logic [19:0] THRESH_RESET = 20'd2560;

	// gesture_mode codes seen by the touch table
	localparam logic [1:0] GMODE_IDLE    = 2'd0;
	localparam logic [1:0] GMODE_DRAG    = 2'd1;
	localparam logic [1:0] GMODE_INERTIA = 2'd2;

	// 0.97 in Q16, rounding half, stop below 0.25 px
	localparam logic [15:0] DECAY_NUM  = 16'd63570;
	localparam logic [15:0] ROUND_HALF = 16'd32768;
	localparam logic [24:0] STOP_MAG   = 25'd64;

	localparam logic signed [26:0] VEL_MAX = 27'sd16777215;
	localparam logic signed [26:0] VEL_MIN = -27'sd16777216;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'b001,
		MODE_DRAG    = 3'b010,
		MODE_INERTIA = 3'b100
	} mode_t;

	typedef struct packed {
		logic        free_touch_present;
		logic [7:0]  free_touch_id;
		logic [19:0] free_touch_y;
		logic [19:0] free_touch_start_y;
		logic        followed_gone;
		logic [19:0] followed_y;
		logic [19:0] followed_start_y;
	} frame_t;

	typedef struct packed {
		logic signed [23:0] scroll_position;
		logic               claim_valid;
		logic [7:0]         claim_id;
		logic               redraw_request;
		logic [7:0]         watched_id;
		logic [1:0]         gesture_mode;
	} result_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [23:0] wdata;
	} cfg_wr_t;

	typedef struct packed {
		logic [19:0]        accept_threshold;
		logic signed [23:0] bound_low;
		logic signed [23:0] bound_high;
	} cfg_regs_t;

	typedef struct packed {
		mode_t              mode;
		logic [7:0]         drag_touch_id;
		logic signed [23:0] position;
		logic signed [23:0] anchor_position;
		logic signed [24:0] velocity;
	} gesture_state_t;

endpackage

### rtl/isg_stream_if.sv
// ----------------------------------------------------------------------------
// isg_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface isg_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### rtl/isg_decay.sv
// ----------------------------------------------------------------------------
// isg_decay
// Velocity decay: magnitude times 0.97 (Q16), rounded to nearest, sign kept.
// ----------------------------------------------------------------------------
module isg_decay (
	input  logic signed [24:0] vel_in,
	output logic signed [24:0] vel_out,
	output logic               stop
);
	import isg_pkg::*;

	logic [24:0] mag_in;
	logic [40:0] prod;
	logic [24:0] mag;

	assign mag_in  = vel_in[24] ? 25'(-vel_in) : vel_in;
	assign prod    = 41'(mag_in) * 41'(DECAY_NUM) + 41'(ROUND_HALF);
	assign mag     = prod[40:16];
	assign stop    = mag < STOP_MAG;
	assign vel_out = vel_in[24] ? 25'(-mag) : mag;

endmodule

### rtl/isg_step.sv
// ----------------------------------------------------------------------------
// isg_step
// One frame of the gesture: mode change, drag or inertia update, clamp.
// ----------------------------------------------------------------------------
module isg_step (
	input  isg_pkg::gesture_state_t st,
	input  isg_pkg::frame_t         frm,
	input  isg_pkg::cfg_regs_t      cfg,
	output isg_pkg::gesture_state_t nxt,
	output isg_pkg::result_t        res
);
	import isg_pkg::*;

	logic               is_drag, is_inertia;
	logic               start_drag, drag_now, gone_eff, release_drag, to_inertia;
	logic               do_drag, do_inertia;
	logic [7:0]         id_cur;
	logic signed [23:0] anchor_cur;
	logic [19:0]        y_cur, sy_cur;
	logic signed [20:0] dy;
	logic [20:0]        dy_mag;
	logic signed [25:0] drag_pos;
	logic signed [26:0] vel_diff;
	logic signed [24:0] vel_sat;
	logic signed [25:0] coast_pos;
	logic signed [25:0] pre_pos;
	logic signed [25:0] lo_ext, hi_ext;
	logic signed [23:0] pos_clamped;
	logic signed [24:0] vel_dec;
	logic               dec_stop;
	logic               claim;
	logic [7:0]         claim_id;

	isg_decay u_decay (
		.vel_in  (st.velocity),
		.vel_out (vel_dec),
		.stop    (dec_stop)
	);

	assign is_drag    = st.mode == MODE_DRAG;
	assign is_inertia = st.mode == MODE_INERTIA;

	// a free touch takes over unless a drag is already running
	assign start_drag   = !is_drag && frm.free_touch_present;
	assign drag_now     = is_drag || start_drag;
	assign gone_eff     = !start_drag && frm.followed_gone;
	assign release_drag = drag_now && gone_eff;
	assign to_inertia   = release_drag && (st.velocity != '0);
	assign do_drag      = drag_now && !gone_eff;
	assign do_inertia   = (is_inertia && !start_drag) || to_inertia;

	assign id_cur     = start_drag ? frm.free_touch_id : st.drag_touch_id;
	assign anchor_cur = start_drag ? st.position : st.anchor_position;
	assign y_cur      = start_drag ? frm.free_touch_y : frm.followed_y;
	assign sy_cur     = start_drag ? frm.free_touch_start_y : frm.followed_start_y;

	assign dy       = $signed({1'b0, y_cur}) - $signed({1'b0, sy_cur});
	assign dy_mag   = dy[20] ? 21'(-dy) : dy;
	assign drag_pos = $signed({{2{anchor_cur[23]}}, anchor_cur})
	                - $signed({{5{dy[20]}}, dy});
	assign vel_diff = $signed({drag_pos[25], drag_pos})
	                - $signed({{3{st.position[23]}}, st.position});

	always_comb begin
		priority if (vel_diff > VEL_MAX) begin
			vel_sat = VEL_MAX[24:0];
		end else if (vel_diff < VEL_MIN) begin
			vel_sat = VEL_MIN[24:0];
		end else begin
			vel_sat = vel_diff[24:0];
		end
	end

	assign coast_pos = $signed({{2{st.position[23]}}, st.position})
	                 + $signed({st.velocity[24], st.velocity});

	always_comb begin
		priority if (do_drag) begin
			pre_pos = drag_pos;
		end else if (do_inertia) begin
			pre_pos = coast_pos;
		end else begin
			pre_pos = {{2{st.position[23]}}, st.position};
		end
	end

	// inverted bounds: below the low bound clamps to low, anything else above high to high
	assign lo_ext = {{2{cfg.bound_low[23]}}, cfg.bound_low};
	assign hi_ext = {{2{cfg.bound_high[23]}}, cfg.bound_high};

	always_comb begin
		priority if (pre_pos < lo_ext) begin
			pos_clamped = cfg.bound_low;
		end else if (pre_pos > hi_ext) begin
			pos_clamped = cfg.bound_high;
		end else begin
			pos_clamped = pre_pos[23:0];
		end
	end

	always_comb begin
		claim    = 1'b0;
		claim_id = '0;
		if (start_drag && is_inertia) begin
			claim    = 1'b1;
			claim_id = frm.free_touch_id;
		end
		if (to_inertia) begin
			claim    = 1'b1;
			claim_id = st.drag_touch_id;
		end
		if (do_drag && (dy_mag > {1'b0, cfg.accept_threshold})) begin
			claim    = 1'b1;
			claim_id = id_cur;
		end
	end

	always_comb begin
		nxt.drag_touch_id   = id_cur;
		nxt.position        = pos_clamped;
		nxt.anchor_position = (start_drag || to_inertia) ? st.position : st.anchor_position;
		priority if (do_drag) begin
			nxt.mode     = MODE_DRAG;
			nxt.velocity = vel_sat;
		end else if (do_inertia) begin
			nxt.mode     = dec_stop ? MODE_IDLE : MODE_INERTIA;
			nxt.velocity = dec_stop ? '0 : vel_dec;
		end else begin
			nxt.mode     = MODE_IDLE;
			nxt.velocity = st.velocity;
		end
	end

	always_comb begin
		res.scroll_position = pos_clamped;
		res.claim_valid     = claim;
		res.claim_id        = claim_id;
		res.redraw_request  = do_inertia;
		res.watched_id      = id_cur;
		unique case (nxt.mode)
			MODE_DRAG:    res.gesture_mode = GMODE_DRAG;
			MODE_INERTIA: res.gesture_mode = GMODE_INERTIA;
			default:      res.gesture_mode = GMODE_IDLE;
		endcase
	end

endmodule

### rtl/inertial_scroll_gesture.sv
// ----------------------------------------------------------------------------
// inertial_scroll_gesture
// Kinetic scrolling: drag follows the touch, release coasts with decay.
// ----------------------------------------------------------------------------
// Usage:
//   frame  - one transfer per redraw tick with the first free touch and the
//            followed touch (the one named by the last watched_id).
//   result - one transfer per frame: clamped scroll position, claim request,
//            redraw request, followed touch id and gesture mode.
//   cfg    - register writes (accept threshold, low bound, high bound);
//            always ready, write only while no frame is in flight.
// Throughput: one frame per cycle while results are taken. The gesture state
//   loops through combinational logic: the 25x16 decay multiply and the
//   position add and clamp.
// Reset: registers return to their defaults (threshold 2560 = 10 px, bounds
//   zero), the gesture goes idle with position and velocity zero.
// Stall: the result register holds until taken; the input register can still
//   take one more frame, after which frame.ready drops.
// ----------------------------------------------------------------------------
module inertial_scroll_gesture #(
	parameter int ID_BITS = 8
) (
	input logic          clk,
	input logic          arst_n,
	isg_stream_if.sink   frame,
	isg_stream_if.source result,
	isg_stream_if.sink   cfg
);
	import isg_pkg::*;

	// identifiers are cut to ID_BITS, and to the 8-bit field
	localparam logic [7:0] ID_MASK = 8'((32'd1 << ID_BITS) - 32'd1);

	cfg_regs_t      cfg_q;
	frame_t         frame_in;
	frame_t         frame_s1;
	logic           frame_v_s1;
	result_t        res_s2;
	logic           res_v_s2;
	gesture_state_t st_q;
	gesture_state_t st_nxt;
	result_t        res_nxt;
	logic           advance;
	cfg_wr_t        cfg_wr;

	// configuration: one register per transfer, indexes past the list ignored
	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accept_threshold <= THRESH_RESET;
			cfg_q.bound_low        <= '0;
			cfg_q.bound_high       <= '0;
		end else if (cfg.valid) begin
			unique case (cfg_wr.index)
				REG_ACCEPT_THRESHOLD: cfg_q.accept_threshold <= cfg_wr.wdata[19:0];
				REG_BOUND_LOW:        cfg_q.bound_low        <= cfg_wr.wdata;
				REG_BOUND_HIGH:       cfg_q.bound_high       <= cfg_wr.wdata;
				default:              ;
			endcase
		end
	end

	// the held frame moves on once the result register is free or emptying
	assign advance     = frame_v_s1 && (!res_v_s2 || result.ready);
	assign frame.ready = !frame_v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_v_s1 <= 1'b0;
		end else if (frame.ready) begin
			frame_v_s1 <= frame.valid;
		end
	end

	always_comb begin
		frame_in               = frame.data;
		frame_in.free_touch_id = frame.data.free_touch_id & ID_MASK;
	end

	always_ff @(posedge clk) begin
		if (frame.valid && frame.ready) begin
			frame_s1 <= frame_in;
		end
	end

	isg_step u_step (
		.st  (st_q),
		.frm (frame_s1),
		.cfg (cfg_q),
		.nxt (st_nxt),
		.res (res_nxt)
	);

	// gesture state commits together with the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode            <= MODE_IDLE;
			st_q.drag_touch_id   <= '0;
			st_q.position        <= '0;
			st_q.anchor_position <= '0;
			st_q.velocity        <= '0;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_s2 <= 1'b0;
		end else if (advance) begin
			res_v_s2 <= 1'b1;
		end else if (result.ready) begin
			res_v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign result.valid = res_v_s2;
	assign result.data  = res_s2;

	// ---- assertions ----
	a_idle_no_velocity: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.mode == MODE_IDLE |-> st_q.velocity == '0)
		else $error("velocity left over in idle");

	a_redraw_not_drag: assert property (@(posedge clk) disable iff (!arst_n)
		res_v_s2 && res_s2.redraw_request |-> res_s2.gesture_mode != GMODE_DRAG)
		else $error("redraw request on a drag frame");

	a_inertia_redraws: assert property (@(posedge clk) disable iff (!arst_n)
		res_v_s2 && res_s2.gesture_mode == GMODE_INERTIA |-> res_s2.redraw_request)
		else $error("inertia frame without redraw request");

	a_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (cfg_q.bound_low <= cfg_q.bound_high) |=>
		res_s2.scroll_position >= $past(cfg_q.bound_low) &&
		res_s2.scroll_position <= $past(cfg_q.bound_high))
		else $error("scroll position outside bounds");

endmodule

### tb/scroll_gesture_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scroll_gesture_checker
// Watches the frame, result and register channels of the scroll gesture
// block, predicts each frame's result and compares it with what comes out.
// ----------------------------------------------------------------------------
module scroll_gesture_checker #(
	parameter int ID_BITS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             frame_valid,
	input  logic             frame_ready,
	input  isg_pkg::frame_t  frame_data,
	input  logic             result_valid,
	input  logic             result_ready,
	input  isg_pkg::result_t result_data,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  isg_pkg::cfg_wr_t cfg_data,
	output int               errors,
	output int               pending,
	output int               results_seen,
	output int               claims_seen,
	output int               coast_seen
);
	import isg_pkg::*;

	localparam int unsigned ID_MASK = (32'd1 << ID_BITS) - 32'd1;

	// register shadow
	logic [19:0]        thresh;
	logic signed [23:0] low_bound;
	logic signed [23:0] high_bound;

	// gesture shadow
	logic [1:0]         mode;
	logic [7:0]         drag_id;
	logic signed [23:0] position;
	logic signed [23:0] anchor;
	logic signed [24:0] velocity;

	result_t frame_results_q[$];

	task automatic advance_gesture(input frame_t f, output result_t r);
		logic [7:0] free_id;
		logic       gone;
		logic       claim;
		logic [7:0] claim_to;
		logic       redraw;
		longint     fy;
		longint     fsy;
		longint     dy;
		longint     pos;
		longint     v;
		longint     mag;

		free_id  = f.free_touch_id & ID_MASK[7:0];
		gone     = f.followed_gone;
		fy       = longint'(f.followed_y);
		fsy      = longint'(f.followed_start_y);
		claim    = 1'b0;
		claim_to = 8'd0;
		redraw   = 1'b0;
		pos      = longint'(position);

		// new touch grabs the gesture; during coasting it is claimed at once
		if (mode != GMODE_DRAG && f.free_touch_present) begin
			if (mode == GMODE_INERTIA) begin
				claim    = 1'b1;
				claim_to = free_id;
			end
			mode     = GMODE_DRAG;
			drag_id  = free_id;
			anchor   = position;
			velocity = '0;
			gone     = 1'b0;
			fy       = longint'(f.free_touch_y);
			fsy      = longint'(f.free_touch_start_y);
		end

		if (mode == GMODE_DRAG && gone) begin
			if (velocity != 0) begin
				mode     = GMODE_INERTIA;
				anchor   = position;
				claim    = 1'b1;
				claim_to = drag_id;
			end else begin
				mode = GMODE_IDLE;
			end
		end

		if (mode == GMODE_DRAG) begin
			dy = fy - fsy;
			pos = longint'(anchor) - dy;
			v = pos - longint'(position);
			if (v > longint'(VEL_MAX))
				v = longint'(VEL_MAX);
			if (v < longint'(VEL_MIN))
				v = longint'(VEL_MIN);
			velocity = v[24:0];
			if ((dy < 0 ? -dy : dy) > longint'(thresh)) begin
				claim    = 1'b1;
				claim_to = drag_id;
			end
		end

		if (mode == GMODE_INERTIA) begin
			redraw = 1'b1;
			v = longint'(velocity);
			pos = pos + v;
			mag = ((v < 0 ? -v : v) * longint'(DECAY_NUM) + longint'(ROUND_HALF)) >> 16;
			v = (v < 0) ? -mag : mag;
			if (mag < longint'(STOP_MAG)) begin
				v = 0;
				mode = GMODE_IDLE;
			end
			velocity = v[24:0];
		end

		// inverted bounds: below the lower bound clamps to it, else above upper to upper
		if (pos < longint'(low_bound))
			pos = longint'(low_bound);
		else if (pos > longint'(high_bound))
			pos = longint'(high_bound);
		position = pos[23:0];

		r.scroll_position = position;
		r.claim_valid     = claim;
		r.claim_id        = claim ? claim_to : 8'd0;
		r.redraw_request  = redraw;
		r.watched_id      = drag_id;
		r.gesture_mode    = mode;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			thresh     = THRESH_RESET;
			low_bound  = '0;
			high_bound = '0;
			mode       = GMODE_IDLE;
			drag_id    = '0;
			position   = '0;
			anchor     = '0;
			velocity   = '0;
			frame_results_q.delete();
		end else begin
			if (result_valid && result_ready) begin
				if (frame_results_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: result with no frame pending: pos=%0d mode=%0d",
							$realtime, result_data.scroll_position, result_data.gesture_mode);
				end else begin
					want = frame_results_q.pop_front();
					results_seen++;
					if (result_data.claim_valid === 1'b1)
						claims_seen++;
					if (result_data.redraw_request === 1'b1)
						coast_seen++;
					if (result_data.scroll_position !== want.scroll_position ||
					    result_data.claim_valid !== want.claim_valid ||
					    result_data.claim_id !== want.claim_id ||
					    result_data.redraw_request !== want.redraw_request ||
					    result_data.watched_id !== want.watched_id ||
					    result_data.gesture_mode !== want.gesture_mode) begin
						errors++;
						if (errors <= 10)
							$display({"%0t: result %0d mismatch\n",
								"  expected pos=%0d claim=%0b/%0h redraw=%0b watched=%0h mode=%0d\n",
								"  actual   pos=%0d claim=%0b/%0h redraw=%0b watched=%0h mode=%0d"},
								$realtime, results_seen,
								want.scroll_position, want.claim_valid, want.claim_id,
								want.redraw_request, want.watched_id, want.gesture_mode,
								result_data.scroll_position, result_data.claim_valid,
								result_data.claim_id, result_data.redraw_request,
								result_data.watched_id, result_data.gesture_mode);
					end
				end
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_data.index)
					REG_ACCEPT_THRESHOLD: thresh = cfg_data.wdata[19:0];
					REG_BOUND_LOW:        low_bound = cfg_data.wdata;
					REG_BOUND_HIGH:       high_bound = cfg_data.wdata;
					default: ;
				endcase
			end

			if (frame_valid && frame_ready) begin
				advance_gesture(frame_data, want);
				frame_results_q.push_back(want);
			end
		end
		pending = frame_results_q.size();
	end

endmodule

### tb/inertial_scroll_gesture_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inertial_scroll_gesture_test
// Drives touch frames and register writes into the scroll gesture block:
// a directed opening over the corner cases, then random drag/release/coast
// gestures mixed with junk frames, under several bound and threshold
// settings and three idling profiles. A checker beside the block predicts
// and compares every result; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module inertial_scroll_gesture_test;
	import isg_pkg::*;

	localparam int ID_BITS    = 8;
	localparam int Y_MAX      = 1023999;       // 4000 px in 1/256 px
	localparam int POS_MIN    = -8388608;
	localparam int POS_MAX    = 8388607;
	localparam logic [19:0] THRESH_MAX = 20'hFFFFF;
	localparam int LONG_HOLD  = 300;           // receiver hold-off, cycles
	localparam int TAIL_CYCLES = 16;           // quiet time before the verdict

	logic clk;
	logic arst_n;

	isg_stream_if #(.payload_t(frame_t))  frame_ch ();
	isg_stream_if #(.payload_t(result_t)) result_ch ();
	isg_stream_if #(.payload_t(cfg_wr_t)) cfg_ch ();

	// idling odds in percent, changed by the main sequence per phase
	int send_idle;
	int recv_idle;
	// long receiver hold-offs: asked by the main sequence, served by the
	// receiver process
	int hold_asks;
	int hold_served;
	int frames_sent;
	int settings_used;

	int errors;
	int pending;
	int results_seen;
	int claims_seen;
	int coast_seen;

	inertial_scroll_gesture #(
		.ID_BITS(ID_BITS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	scroll_gesture_checker #(
		.ID_BITS(ID_BITS)
	) checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_valid  (frame_ch.valid),
		.frame_ready  (frame_ch.ready),
		.frame_data   (frame_ch.data),
		.result_valid (result_ch.valid),
		.result_ready (result_ch.ready),
		.result_data  (result_ch.data),
		.cfg_valid    (cfg_ch.valid),
		.cfg_ready    (cfg_ch.ready),
		.cfg_data     (cfg_ch.data),
		.errors       (errors),
		.pending      (pending),
		.results_seen (results_seen),
		.claims_seen  (claims_seen),
		.coast_seen   (coast_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the handshake hangs.
	initial begin
		#5_000_000;
		$display("timeout: %0d frames sent, %0d results checked", frames_sent, results_seen);
		$display("FAIL inertial_scroll_gesture");
		$finish;
	end

	// Result side. Ready changes only at falling edges, one assignment per
	// edge; a pending hold-off request keeps it low through a long hold-off.
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_asks != hold_served) begin
				result_ch.ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				hold_served++;
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
			end
		end
	end

	function automatic frame_t make_frame(logic present, logic [7:0] id, int y, int sy,
	                                      logic gone, int fy, int fsy);
		frame_t f;
		f.free_touch_present = present;
		f.free_touch_id      = id;
		f.free_touch_y       = y[19:0];
		f.free_touch_start_y = sy[19:0];
		f.followed_gone      = gone;
		f.followed_y         = fy[19:0];
		f.followed_start_y   = fsy[19:0];
		return f;
	endfunction

	// anything legal in every field
	function automatic frame_t junk_frame();
		return make_frame(1'($urandom), 8'($urandom), $urandom_range(0, Y_MAX),
			$urandom_range(0, Y_MAX), 1'($urandom), $urandom_range(0, Y_MAX),
			$urandom_range(0, Y_MAX));
	endfunction

	function automatic int keep_on_screen(int y);
		return (y < 0) ? 0 : ((y > Y_MAX) ? Y_MAX : y);
	endfunction

	// Offer one frame; entered and left at a falling edge. Valid stays high
	// on return so back-to-back frames never drop it in between.
	task automatic push_frame(input frame_t f);
		bit taken;
		while ($urandom_range(0, 99) < send_idle) begin
			frame_ch.valid <= 1'b0;
			@(negedge clk);
		end
		frame_ch.valid <= 1'b1;
		frame_ch.data  <= f;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = frame_ch.ready;
			@(negedge clk);
		end
		frames_sent++;
	endtask

	// Stop offering and wait until every frame's result has been taken.
	task automatic settle();
		frame_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [23:0] value);
		bit taken;
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= cfg_wr_t'{index: idx, wdata: value};
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = cfg_ch.ready;
			@(negedge clk);
		end
	endtask

	// Registers move only with the block drained.
	task automatic retune(input logic [19:0] thresh, input int low, input int high);
		settle();
		write_reg(REG_ACCEPT_THRESHOLD, {4'd0, thresh});
		write_reg(REG_BOUND_LOW, low[23:0]);
		write_reg(REG_BOUND_HIGH, high[23:0]);
		cfg_ch.valid <= 1'b0;
		settings_used++;
	endtask

	// One finger gesture: touch down, a few drag frames, lift, then coast
	// frames with no free touch. The next gesture's touch may cut the coast.
	task automatic run_gesture();
		logic [7:0] id;
		int sy;
		int y;
		int spread;
		int steps;
		int coast;
		logic other;

		id = 8'($urandom);
		sy = $urandom_range(0, Y_MAX);
		y  = keep_on_screen(sy + int'($urandom_range(0, 6000)) - 3000);
		// followed fields are stale here, the free touch drives the first frame
		push_frame(make_frame(1'b1, id, y, sy, 1'($urandom), $urandom_range(0, Y_MAX),
			$urandom_range(0, Y_MAX)));

		steps = $urandom_range(1, 12);
		repeat (steps) begin
			spread = ($urandom_range(0, 9) == 0) ? 200000 : 3000;
			// some frames hold still so a lift can come with zero velocity
			if ($urandom_range(0, 3) != 0)
				y = keep_on_screen(y + int'($urandom_range(0, 2 * spread)) - spread);
			// a second finger now and then, ignored while dragging
			other = ($urandom_range(0, 5) == 0);
			push_frame(make_frame(other, 8'($urandom), $urandom_range(0, Y_MAX),
				$urandom_range(0, Y_MAX), 1'b0, y, sy));
		end

		// lift
		push_frame(make_frame(1'b0, 8'($urandom), $urandom_range(0, Y_MAX),
			$urandom_range(0, Y_MAX), 1'b1, $urandom_range(0, Y_MAX),
			$urandom_range(0, Y_MAX)));

		case ($urandom_range(0, 2))
			0: coast = $urandom_range(0, 10);
			1: coast = $urandom_range(10, 60);
			default: coast = $urandom_range(60, 200);
		endcase
		repeat (coast)
			push_frame(make_frame(1'b0, 8'($urandom), $urandom_range(0, Y_MAX),
				$urandom_range(0, Y_MAX), 1'($urandom), $urandom_range(0, Y_MAX),
				$urandom_range(0, Y_MAX)));
	endtask

	// Mostly well formed gestures, some junk frames that break them up.
	task automatic run_phase(input logic [19:0] thresh, input int low, input int high,
	                         input int count, input bit long_hold);
		int stop_at;
		retune(thresh, low, high);
		if (long_hold)
			hold_asks++;
		stop_at = frames_sent + count;
		while (frames_sent < stop_at) begin
			if ($urandom_range(0, 99) < 15)
				repeat ($urandom_range(1, 4)) push_frame(junk_frame());
			else
				run_gesture();
		end
	endtask

	initial begin
		logic [19:0] rt;
		int rl;
		int rh;

		arst_n         = 1'b0;
		frame_ch.valid = 1'b0;
		frame_ch.data  = '0;
		cfg_ch.valid   = 1'b0;
		cfg_ch.data    = '0;
		send_idle      = 19;
		recv_idle      = 84;
		hold_asks      = 0;
		hold_served    = 0;
		frames_sent    = 0;
		settings_used  = 1;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed, reset settings: bounds pinned at zero ---
		push_frame(make_frame(1'b0, 8'h00, 0, 0, 1'b0, 0, 0));
		// all fields high but no free touch: stays idle
		push_frame(make_frame(1'b0, 8'hFF, Y_MAX, Y_MAX, 1'b1, Y_MAX, Y_MAX));
		// touch down with the largest travel; gone is ignored on a new drag
		push_frame(make_frame(1'b1, 8'hFF, Y_MAX, 0, 1'b1, 0, Y_MAX));
		// lift with motion: coast starts, touch claimed
		push_frame(make_frame(1'b0, 8'h00, 0, 0, 1'b1, 0, 0));
		// touch during coasting is claimed right away
		push_frame(make_frame(1'b1, 8'h00, 0, 0, 1'b0, 0, 0));
		// lift with no motion: straight to idle
		push_frame(make_frame(1'b0, 8'h00, 0, 0, 1'b1, 0, 0));

		// --- full range bounds, threshold edge ---
		retune(20'd1000, POS_MIN, POS_MAX);
		push_frame(make_frame(1'b1, 8'h5A, 5000, 4000, 1'b0, 0, 0));    // travel at threshold
		push_frame(make_frame(1'b0, 8'h00, 0, 0, 1'b0, 5001, 4000));    // one past it
		push_frame(make_frame(1'b0, 8'h00, 0, 0, 1'b0, 5001, 4000));
		push_frame(make_frame(1'b0, 8'h00, 0, 0, 1'b1, 0, 0));
		push_frame(make_frame(1'b1, 8'hA5, 100000, 100000, 1'b0, 0, 0));
		push_frame(make_frame(1'b1, 8'h3C, 7, 9, 1'b0, 0, 100000));     // fast swipe
		push_frame(make_frame(1'b0, 8'h00, 0, 0, 1'b1, 0, 0));
		repeat (3) push_frame(make_frame(1'b0, 8'($urandom), $urandom_range(0, Y_MAX),
			$urandom_range(0, Y_MAX), 1'($urandom), $urandom_range(0, Y_MAX),
			$urandom_range(0, Y_MAX)));
		push_frame(make_frame(1'b1, 8'h81, 300, 300, 1'b0, 0, 0));
		push_frame(make_frame(1'b0, 8'h00, 0, 0, 1'b1, 0, 0));

		// --- park the position at the top, then flip the bounds so the next
		// drag jumps across the whole range and velocity saturates high ---
		retune(20'd0, POS_MAX, POS_MAX);
		push_frame(make_frame(1'b0, 8'h00, 0, 0, 1'b0, 0, 0));
		retune(THRESH_MAX, POS_MIN, POS_MIN);
		push_frame(make_frame(1'b1, 8'h33, 0, 1000, 1'b0, 0, 0));
		push_frame(make_frame(1'b0, 8'h00, 0, 0, 1'b0, 0, 1000));
		push_frame(make_frame(1'b0, 8'h00, 0, 0, 1'b1, 0, 0));
		push_frame(make_frame(1'b1, 8'hCC, 500, 500, 1'b0, 0, 0));
		push_frame(make_frame(1'b0, 8'h00, 0, 0, 1'b1, 0, 0));
		// same the other way: saturate low, leave it coasting
		retune(THRESH_MAX, POS_MAX, POS_MAX);
		push_frame(make_frame(1'b1, 8'h01, 1000, 0, 1'b0, 0, 0));
		push_frame(make_frame(1'b0, 8'h00, 0, 0, 1'b0, 1000, 0));
		push_frame(make_frame(1'b0, 8'h00, 0, 0, 1'b1, 0, 0));

		// --- random: slow receiver ---
		run_phase(20'd2560, -4000000, 4000000, 300, 1'b0);
		run_phase(20'd0, POS_MIN, POS_MAX, 310, 1'b0);

		// --- random: slow sender, inverted and arbitrary bounds ---
		send_idle = 84;
		recv_idle = 19;
		run_phase(THRESH_MAX, 500000, -500000, 310, 1'b0);
		rt = 20'($urandom);
		rl = $signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8;
		rh = rl + int'($urandom_range(0, 2000000));
		if (rh > POS_MAX)
			rh = POS_MAX;
		run_phase(rt, rl, rh, 310, 1'b0);

		// --- random: no idling; the first phase opens with a long result
		// hold-off while frames keep coming, so the block backs up ---
		send_idle = 0;
		recv_idle = 0;
		run_phase(20'd1000, -200000, 200000, 310, 1'b1);
		rt = 20'($urandom);
		rl = $signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8;
		rh = $signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8;
		run_phase(rt, rl, rh, 310, 1'b0);

		settle();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("run covered %0d frames over %0d register settings", frames_sent,
			settings_used);
		$display("  %0d results checked, %0d claims, %0d coasting frames, %0d errors",
			results_seen, claims_seen, coast_seen, errors);
		if (errors == 0 && pending == 0)
			$display("PASS inertial_scroll_gesture");
		else
			$display("FAIL inertial_scroll_gesture");
		$finish;
	end

endmodule
